// ===== rtl/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

  localparam int MEM_LOG2     = 20;
  localparam int MIN_LOG2     = 10;
  localparam int HEADER_BYTES = 8;

  localparam int LEAF_DEPTH = MEM_LOG2 - MIN_LOG2;
  localparam int NODE_COUNT = (1 << (LEAF_DEPTH + 1)) - 1;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int DEPTH_W    = $clog2(LEAF_DEPTH + 1);
  localparam int IDX_W      = (LEAF_DEPTH > 0) ? LEAF_DEPTH : 1;
  localparam int SH_W       = $clog2(MEM_LOG2 + 1);
  localparam int ADDR_W     = 20;
  localparam int SIZE_W     = 21;

  typedef enum logic [1:0] {
    NS_UNUSED = 2'd0,
    NS_FREE   = 2'd1,
    NS_SPLIT  = 2'd2,
    NS_ALLOC  = 2'd3
  } node_state_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_TOOBIG  = 2'd2,
    ST_BADADDR = 2'd3
  } result_code_t;

  typedef enum logic [2:0] {
    AS_NODE, AS_LCHILD, AS_RCHILD, AS_BUDDY, AS_PARENT, AS_SCAN, AS_FREE, AS_CLR
  } addr_sel_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_START,
    S_SCAN_RD, S_SCAN_CHK,
    S_SPLIT_CHK, S_SP_W0, S_SP_W1, S_SP_W2, S_WR_ALLOC,
    S_FR_CHK, S_FR_EVAL, S_FR_SET,
    S_M_CHK, S_M_EVAL, S_M_W0, S_M_W1, S_M_W2,
    S_FIN
  } state_t;

  typedef struct packed {
    logic         load_req;
    logic         mem_rd;
    logic         mem_we;
    addr_sel_t    addr_sel;
    node_state_t  wdata;
    logic         clr_inc;
    logic         scan_next;
    logic         set_node_scan;
    logic         set_node_free;
    logic         split_step;
    logic         free_next_d;
    logic         merge_step;
    logic         set_code;
    result_code_t code;
    logic         res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic        req_free;
    logic        too_big;
    logic        addr_low;
    logic        clr_done;
    logic        node_root_clr;
    node_state_t rdata;
    logic        i_last;
    logic        d_zero;
    logic        d_lt_target;
    logic        aligned;
    logic        d_leaf;
    logic        node_root;
    logic        out_full;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/buddy_block_allocator.sv =====
`default_nettype none
// Binary buddy allocator over a 1 MiB space, 1 KiB minimum block.
// Input channel: in_valid / in_stall carry one request (req_type,
// req_size, free_addr). A request is taken when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall carry one
// result (status, block_addr) per request, held while stalled.
// Requests are handled one at a time. Latency depends on the tree walk
// through the single-port node-status RAM (one read or write per cycle):
//   alloc: one read per node scanned from the target level upward, then
//          per split level the node is written split and both children free.
//   free:  one alignment check per tree level probed, with a read where aligned;
//          per merge the buddy is read, then node and buddy are written unused
//          and the parent free.
// The result sits in an output register, so the block goes back to
// taking requests while it waits; a finished result waits in its last
// state only if the previous result is still stalled.
// Reset (rst, synchronous) starts a clearing pass over all 2047 nodes that
// writes the root free and every other node unused; in_stall is high
// during that pass.
module buddy_block_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       req_type,
  input  wire logic [bba_pkg::SIZE_W-1:0] req_size,
  input  wire logic [bba_pkg::ADDR_W-1:0] free_addr,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      status,
  output logic [bba_pkg::ADDR_W-1:0]      block_addr
);

  bba_pkg::dp_cmd_t  cmd;
  bba_pkg::dp_stat_t stat;

  // sequencer: clearing pass, search, split and merge steps
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // node RAM, walk registers and the result register
  bba_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .req_size   (req_size),
    .free_addr  (free_addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .block_addr (block_addr)
  );

endmodule
`default_nettype wire

// ===== rtl/bba_datapath.sv =====
`default_nettype none
module bba_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire bba_pkg::dp_cmd_t                     cmd,
  output bba_pkg::dp_stat_t                         stat,
  input  wire logic                                 req_type,
  input  wire logic [bba_pkg::SIZE_W-1:0]           req_size,
  input  wire logic [bba_pkg::ADDR_W-1:0]           free_addr,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [1:0]                                status,
  output logic [bba_pkg::ADDR_W-1:0]                block_addr
);

  localparam int NW = bba_pkg::NODE_W;
  localparam int DW = bba_pkg::DEPTH_W;
  localparam int IW = bba_pkg::IDX_W;
  localparam int AW = bba_pkg::ADDR_W;
  localparam int SW = bba_pkg::SH_W;

  logic [1:0] mem [bba_pkg::NODE_COUNT];
  logic [1:0] rdata;

  logic          type_q, big_q, low_q;
  logic [AW-1:0] abs_q;
  logic [DW-1:0] d, target;
  logic [IW-1:0] i;
  logic [NW-1:0] node, clr_cnt;
  logic [1:0]    code_q;
  logic [AW-1:0] pend_addr;

  // size rounding on the incoming request
  logic [4:0]    msb;
  logic          in_big;
  logic [DW-1:0] in_target;
  always_comb begin
    msb = '0;
    for (int k = 0; k < bba_pkg::SIZE_W; k++) begin
      if (req_size[k]) msb = 5'(k);
    end
  end
  always_comb begin
    logic [5:0] p;
    if (req_size <= bba_pkg::SIZE_W'(1 << bba_pkg::MIN_LOG2)) p = 6'(bba_pkg::MIN_LOG2);
    else p = 6'(msb) + 6'd1;
    in_big    = p > 6'(bba_pkg::MEM_LOG2);
    in_target = DW'(6'(bba_pkg::MEM_LOG2) - p);
  end

  logic [NW-1:0] base_d, scan_addr, free_node, buddy, parent, addr;
  logic [SW-1:0] sh;
  logic [AW:0]   mask;
  logic [AW-1:0] alloc_addr;
  always_comb begin
    base_d    = NW'((NW+1)'(1) << d) - NW'(1);
    scan_addr = base_d + NW'(i);
    sh        = SW'(bba_pkg::MEM_LOG2) - SW'(d);
    mask      = ((AW+1)'(1) << sh) - (AW+1)'(1);
    free_node = base_d + NW'(abs_q >> sh);
    buddy     = node[0] ? node + NW'(1) : node - NW'(1);
    parent    = (node - NW'(1)) >> 1;
    alloc_addr = (AW'(i) << sh) + AW'(bba_pkg::HEADER_BYTES);
    case (cmd.addr_sel)
      bba_pkg::AS_NODE:   addr = node;
      bba_pkg::AS_LCHILD: addr = (node << 1) + NW'(1);
      bba_pkg::AS_RCHILD: addr = (node << 1) + NW'(2);
      bba_pkg::AS_BUDDY:  addr = buddy;
      bba_pkg::AS_PARENT: addr = parent;
      bba_pkg::AS_SCAN:   addr = scan_addr;
      bba_pkg::AS_FREE:   addr = free_node;
      default:            addr = clr_cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[addr] <= cmd.wdata;
    if (cmd.mem_rd) rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_inc) clr_cnt <= clr_cnt + NW'(1);
      if (cmd.res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      type_q <= req_type;
      big_q  <= in_big;
      low_q  <= free_addr < AW'(bba_pkg::HEADER_BYTES);
      abs_q  <= free_addr - AW'(bba_pkg::HEADER_BYTES);
      target <= in_target;
      d      <= req_type ? '0 : in_target;
      i      <= '0;
    end
    if (cmd.scan_next) begin
      if (stat.i_last) begin
        d <= d - DW'(1);
        i <= '0;
      end else begin
        i <= i + IW'(1);
      end
    end
    if (cmd.set_node_scan) node <= scan_addr;
    if (cmd.set_node_free) node <= free_node;
    if (cmd.split_step) begin
      node <= (node << 1) + NW'(1);
      i    <= i << 1;
      d    <= d + DW'(1);
    end
    if (cmd.free_next_d) d <= d + DW'(1);
    if (cmd.merge_step) node <= parent;
    if (cmd.set_code) begin
      code_q    <= cmd.code;
      pend_addr <= (cmd.code == bba_pkg::ST_OK && !type_q) ? alloc_addr : '0;
    end
    if (cmd.res_load) begin
      status     <= code_q;
      block_addr <= pend_addr;
    end
  end

  always_comb begin
    stat.req_free      = type_q;
    stat.too_big       = big_q;
    stat.addr_low      = low_q;
    stat.clr_done      = clr_cnt == NW'(bba_pkg::NODE_COUNT - 1);
    stat.node_root_clr = clr_cnt == '0;
    stat.rdata         = bba_pkg::node_state_t'(rdata);
    stat.i_last        = {1'b0, i} == (IW+1)'(((IW+1)'(1) << d) - (IW+1)'(1));
    stat.d_zero        = d == '0;
    stat.d_lt_target   = d < target;
    stat.aligned       = ({1'b0, abs_q} & mask) == '0;
    stat.d_leaf        = d == DW'(bba_pkg::LEAF_DEPTH);
    stat.node_root     = node == '0;
    stat.out_full      = out_valid && out_stall;
  end

endmodule
`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
`default_nettype none
module bba_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t      cmd
);

  bba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bba_pkg::S_CLR;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.addr_sel = bba_pkg::AS_NODE;
    cmd.wdata    = bba_pkg::NS_UNUSED;
    cmd.code     = bba_pkg::ST_OK;
    in_stall     = state != bba_pkg::S_IDLE;
    unique case (state)
      bba_pkg::S_CLR: begin
        cmd.mem_we   = 1'b1;
        cmd.addr_sel = bba_pkg::AS_CLR;
        cmd.wdata    = stat.node_root_clr ? bba_pkg::NS_FREE : bba_pkg::NS_UNUSED;
        cmd.clr_inc  = !stat.clr_done;
        if (stat.clr_done) state_next = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = bba_pkg::S_START;
        end
      end
      bba_pkg::S_START: begin
        if (!stat.req_free) begin
          if (stat.too_big) begin
            cmd.set_code = 1'b1;
            cmd.code     = bba_pkg::ST_TOOBIG;
            state_next   = bba_pkg::S_FIN;
          end else state_next = bba_pkg::S_SCAN_RD;
        end else if (stat.addr_low) begin
          cmd.set_code = 1'b1;
          cmd.code     = bba_pkg::ST_BADADDR;
          state_next   = bba_pkg::S_FIN;
        end else state_next = bba_pkg::S_FR_CHK;
      end
      bba_pkg::S_SCAN_RD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = bba_pkg::AS_SCAN;
        state_next   = bba_pkg::S_SCAN_CHK;
      end
      bba_pkg::S_SCAN_CHK: begin
        if (stat.rdata == bba_pkg::NS_FREE) begin
          cmd.set_node_scan = 1'b1;
          state_next        = bba_pkg::S_SPLIT_CHK;
        end else if (stat.i_last && stat.d_zero) begin
          cmd.set_code = 1'b1;
          cmd.code     = bba_pkg::ST_NOSPACE;
          state_next   = bba_pkg::S_FIN;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = bba_pkg::S_SCAN_RD;
        end
      end
      bba_pkg::S_SPLIT_CHK: begin
        state_next = stat.d_lt_target ? bba_pkg::S_SP_W0 : bba_pkg::S_WR_ALLOC;
      end
      bba_pkg::S_SP_W0: begin
        cmd.mem_we = 1'b1;
        cmd.wdata  = bba_pkg::NS_SPLIT;
        state_next = bba_pkg::S_SP_W1;
      end
      bba_pkg::S_SP_W1: begin
        cmd.mem_we   = 1'b1;
        cmd.addr_sel = bba_pkg::AS_LCHILD;
        cmd.wdata    = bba_pkg::NS_FREE;
        state_next   = bba_pkg::S_SP_W2;
      end
      bba_pkg::S_SP_W2: begin
        cmd.mem_we     = 1'b1;
        cmd.addr_sel   = bba_pkg::AS_RCHILD;
        cmd.wdata      = bba_pkg::NS_FREE;
        cmd.split_step = 1'b1;
        state_next     = bba_pkg::S_SPLIT_CHK;
      end
      bba_pkg::S_WR_ALLOC: begin
        cmd.mem_we   = 1'b1;
        cmd.wdata    = bba_pkg::NS_ALLOC;
        cmd.set_code = 1'b1;
        cmd.code     = bba_pkg::ST_OK;
        state_next   = bba_pkg::S_FIN;
      end
      bba_pkg::S_FR_CHK: begin
        if (stat.aligned) begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = bba_pkg::AS_FREE;
          state_next   = bba_pkg::S_FR_EVAL;
        end else if (stat.d_leaf) begin
          cmd.set_code = 1'b1;
          cmd.code     = bba_pkg::ST_BADADDR;
          state_next   = bba_pkg::S_FIN;
        end else cmd.free_next_d = 1'b1;
      end
      bba_pkg::S_FR_EVAL: begin
        if (stat.rdata == bba_pkg::NS_ALLOC) begin
          cmd.set_node_free = 1'b1;
          state_next        = bba_pkg::S_FR_SET;
        end else if (stat.d_leaf) begin
          cmd.set_code = 1'b1;
          cmd.code     = bba_pkg::ST_BADADDR;
          state_next   = bba_pkg::S_FIN;
        end else begin
          cmd.free_next_d = 1'b1;
          state_next      = bba_pkg::S_FR_CHK;
        end
      end
      bba_pkg::S_FR_SET: begin
        cmd.mem_we = 1'b1;
        cmd.wdata  = bba_pkg::NS_FREE;
        state_next = bba_pkg::S_M_CHK;
      end
      bba_pkg::S_M_CHK: begin
        if (stat.node_root) begin
          cmd.set_code = 1'b1;
          cmd.code     = bba_pkg::ST_OK;
          state_next   = bba_pkg::S_FIN;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = bba_pkg::AS_BUDDY;
          state_next   = bba_pkg::S_M_EVAL;
        end
      end
      bba_pkg::S_M_EVAL: begin
        if (stat.rdata != bba_pkg::NS_FREE) begin
          cmd.set_code = 1'b1;
          cmd.code     = bba_pkg::ST_OK;
          state_next   = bba_pkg::S_FIN;
        end else state_next = bba_pkg::S_M_W0;
      end
      bba_pkg::S_M_W0: begin
        cmd.mem_we = 1'b1;
        state_next = bba_pkg::S_M_W1;
      end
      bba_pkg::S_M_W1: begin
        cmd.mem_we   = 1'b1;
        cmd.addr_sel = bba_pkg::AS_BUDDY;
        state_next   = bba_pkg::S_M_W2;
      end
      bba_pkg::S_M_W2: begin
        cmd.mem_we     = 1'b1;
        cmd.addr_sel   = bba_pkg::AS_PARENT;
        cmd.wdata      = bba_pkg::NS_FREE;
        cmd.merge_step = 1'b1;
        state_next     = bba_pkg::S_M_CHK;
      end
      bba_pkg::S_FIN: begin
        if (!stat.out_full) begin
          cmd.res_load = 1'b1;
          state_next   = bba_pkg::S_IDLE;
        end
      end
      default: state_next = bba_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
